// ===== rtl/core/lrc_pkg.sv =====
// Shared constants, phase codes and control structs for the LRU tag cache.
package lrc_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int DEFAULT_SIZE = 1000;

    localparam int FONT_W  = 8;
    localparam int CODE_W  = 21;
    localparam int CAP_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int TOTAL_W = 32;
    localparam int LIVE_W  = 7;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 80;
    localparam int FLAG_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PH_W-1:0] PH_LOAD   = 4'd1;
    localparam logic [PH_W-1:0] PH_SCAN   = 4'd2;
    localparam logic [PH_W-1:0] PH_DECIDE = 4'd3;
    localparam logic [PH_W-1:0] PH_UPD    = 4'd4;
    localparam logic [PH_W-1:0] PH_FILL   = 4'd5;
    localparam logic [PH_W-1:0] PH_MARK   = 4'd6;
    localparam logic [PH_W-1:0] PH_MAP    = 4'd7;
    localparam logic [PH_W-1:0] PH_RM0    = 4'd8;
    localparam logic [PH_W-1:0] PH_RM1    = 4'd9;
    localparam logic [PH_W-1:0] PH_RM2    = 4'd10;
    localparam logic [PH_W-1:0] PH_DONE   = 4'd11;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            take;
        logic            proc;
        logic            emit;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic font_zero;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/lrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

endmodule

// ===== rtl/core/lrc_ctrl.sv =====
// Sequencer for the LRU tag cache: walks the entry sweeps of each item.
module lrc_ctrl #(
    parameter int ENTRIES = lrc_pkg::ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  lrc_pkg::stat_t             stat,
    output lrc_pkg::cmd_t              cmd,
    output logic [$clog2(ENTRIES+1)-1:0] idx,
    output logic [$clog2(ENTRIES)-1:0]   pidx
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [lrc_pkg::PH_W-1:0] state_reg, state_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [IW-1:0]            pidx_reg, pidx_next;
    logic                     proc_reg, proc_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        proc_next  = 1'b0;
        unique case (state_reg)
            lrc_pkg::PH_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lrc_pkg::PH_LOAD;
                end
            end
            lrc_pkg::PH_LOAD:
            begin
                idx_next = '0;
                priority if (stat.is_clear)
                begin
                    state_next = lrc_pkg::PH_MARK;
                end
                else if (stat.font_zero)
                begin
                    state_next = lrc_pkg::PH_DONE;
                end
                else
                begin
                    state_next = lrc_pkg::PH_SCAN;
                end
            end
            lrc_pkg::PH_SCAN, lrc_pkg::PH_UPD, lrc_pkg::PH_MARK:
            begin
                // one read issued per cycle; the last read's data is handled while idx sits at ENTRIES
                if (idx_reg == CW'(ENTRIES))
                begin
                    idx_next = '0;
                    priority if (state_reg == lrc_pkg::PH_SCAN)
                    begin
                        state_next = lrc_pkg::PH_DECIDE;
                    end
                    else if (state_reg == lrc_pkg::PH_UPD)
                    begin
                        state_next = lrc_pkg::PH_FILL;
                    end
                    else
                    begin
                        state_next = lrc_pkg::PH_MAP;
                    end
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    pidx_next = idx_reg[IW-1:0];
                    proc_next = 1'b1;
                end
            end
            lrc_pkg::PH_DECIDE:
            begin
                state_next = lrc_pkg::PH_UPD;
            end
            lrc_pkg::PH_FILL:
            begin
                state_next = lrc_pkg::PH_DONE;
            end
            lrc_pkg::PH_MAP:
            begin
                if (idx_reg == CW'(ENTRIES - 1))
                begin
                    idx_next   = '0;
                    state_next = lrc_pkg::PH_RM0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lrc_pkg::PH_RM0:
            begin
                state_next = lrc_pkg::PH_RM1;
            end
            lrc_pkg::PH_RM1:
            begin
                state_next = lrc_pkg::PH_RM2;
            end
            lrc_pkg::PH_RM2:
            begin
                if (idx_reg == CW'(ENTRIES - 1))
                begin
                    idx_next   = '0;
                    state_next = lrc_pkg::PH_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = lrc_pkg::PH_RM0;
                end
            end
            lrc_pkg::PH_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = lrc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                state_next = lrc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrc_pkg::PH_IDLE;
            idx_reg   <= '0;
            pidx_reg  <= '0;
            proc_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pidx_reg  <= pidx_next;
            proc_reg  <= proc_next;
        end
    end

    assign s_tready  = (state_reg == lrc_pkg::PH_IDLE);
    assign cmd.phase = state_reg;
    assign cmd.take  = (state_reg == lrc_pkg::PH_IDLE) && s_tvalid;
    assign cmd.proc  = proc_reg;
    assign cmd.emit  = (state_reg == lrc_pkg::PH_DONE) && stat.out_free;
    assign idx       = idx_reg;
    assign pidx      = pidx_reg;

endmodule

// ===== rtl/core/lrc_dpath.sv =====
// Datapath of the LRU tag cache: tag/rank RAM, valid bits, counters, result register.
module lrc_dpath #(
    parameter int ENTRIES = lrc_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrc_pkg::cmd_t                cmd,
    input  logic [$clog2(ENTRIES+1)-1:0] idx,
    input  logic [$clog2(ENTRIES)-1:0]   pidx,
    input  logic [lrc_pkg::IN_W-1:0]     s_tdata,
    input  logic                         s_tuser,
    input  logic                         cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0]    cfg_wdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lrc_pkg::OUT_W-1:0]    m_tdata,
    output logic [lrc_pkg::FLAG_W-1:0]   m_tuser,
    output lrc_pkg::stat_t               stat
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = lrc_pkg::FONT_W + lrc_pkg::CODE_W + IW;
    localparam int DEF_EFF = (lrc_pkg::DEFAULT_SIZE > ENTRIES) ? ENTRIES : lrc_pkg::DEFAULT_SIZE;
    localparam logic [8:0] N9   = 9'(ENTRIES);
    localparam logic [8:0] DEF9 = 9'(DEF_EFF);

    // tag RAM word: {font, code, rank}
    logic          tag_we;
    logic [IW-1:0] tag_waddr;
    logic [WW-1:0] tag_wdata;
    logic [WW-1:0] tag_q;
    logic          map_we;
    logic [IW-1:0] map_wdata;
    logic [IW-1:0] map_q;

    logic [IW-1:0]                 q_rank;
    logic [lrc_pkg::CODE_W-1:0]    q_code;
    logic [lrc_pkg::FONT_W-1:0]    q_font;

    logic                          kind_reg, kind_next;
    logic [lrc_pkg::FONT_W-1:0]    font_reg, font_next;
    logic [lrc_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [lrc_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic [ENTRIES-1:0]            valid_reg, valid_next;
    logic [ENTRIES-1:0]            removed_reg, removed_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 rm_cnt_reg, rm_cnt_next;
    logic [lrc_pkg::TOTAL_W-1:0]   hit_tot_reg, hit_tot_next;
    logic [lrc_pkg::TOTAL_W-1:0]   miss_tot_reg, miss_tot_next;
    logic                          found_reg, found_next;
    logic [IW-1:0]                 hit_idx_reg, hit_idx_next;
    logic [IW-1:0]                 hit_rank_reg, hit_rank_next;
    logic                          lru_have_reg, lru_have_next;
    logic [IW-1:0]                 lru_idx_reg, lru_idx_next;
    logic [IW-1:0]                 lru_rank_reg, lru_rank_next;
    logic                          free_have_reg, free_have_next;
    logic [IW-1:0]                 free_idx_reg, free_idx_next;
    logic [IW-1:0]                 tgt_reg, tgt_next;
    logic [IW:0]                   thr_reg, thr_next;
    logic                          is_hit_reg, is_hit_next;
    logic                          is_evict_reg, is_evict_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lrc_pkg::OUT_W-1:0]     out_data_reg, out_data_next;
    logic [lrc_pkg::FLAG_W-1:0]    out_user_reg, out_user_next;

    logic [8:0] cap9;
    logic [8:0] eff9;
    logic       lookup;

    assign q_rank = tag_q[IW-1:0];
    assign q_code = tag_q[IW +: lrc_pkg::CODE_W];
    assign q_font = tag_q[IW + lrc_pkg::CODE_W +: lrc_pkg::FONT_W];

    assign cap9   = {2'b00, cap_reg};
    assign eff9   = (cap_reg == '0) ? DEF9 : ((cap9 > N9) ? N9 : cap9);
    assign lookup = (kind_reg == lrc_pkg::KIND_LOOKUP) && (font_reg != '0);

    lrc_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (idx[IW-1:0]),
        .q     (tag_q)
    );

    lrc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (idx[IW-1:0]),
        .wdata (map_wdata),
        .raddr (q_rank),
        .q     (map_q)
    );

    // rank remap table: old rank -> old rank minus removed entries ranked above it
    assign map_we    = (cmd.phase == lrc_pkg::PH_MAP);
    assign map_wdata = IW'(idx - rm_cnt_reg);

    always_comb
    begin
        tag_we    = 1'b0;
        tag_waddr = pidx;
        tag_wdata = {q_font, q_code, q_rank + 1'b1};
        priority if (cmd.phase == lrc_pkg::PH_UPD)
        begin
            // age entries more recent than the threshold, skip the target
            tag_we = cmd.proc && valid_reg[pidx] && (pidx != tgt_reg)
                     && ({1'b0, q_rank} < thr_reg);
        end
        else if (cmd.phase == lrc_pkg::PH_FILL)
        begin
            tag_we    = 1'b1;
            tag_waddr = tgt_reg;
            tag_wdata = {font_reg, code_reg, IW'(0)};
        end
        else if (cmd.phase == lrc_pkg::PH_RM2)
        begin
            tag_we    = valid_reg[idx[IW-1:0]];
            tag_waddr = idx[IW-1:0];
            tag_wdata = {q_font, q_code, map_q};
        end
        else
        begin
            tag_we = 1'b0;
        end
    end

    always_comb
    begin
        kind_next      = kind_reg;
        font_next      = font_reg;
        code_next      = code_reg;
        cap_next       = cap_reg;
        valid_next     = valid_reg;
        removed_next   = removed_reg;
        count_next     = count_reg;
        rm_cnt_next    = rm_cnt_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        lru_have_next  = lru_have_reg;
        lru_idx_next   = lru_idx_reg;
        lru_rank_next  = lru_rank_reg;
        free_have_next = free_have_reg;
        free_idx_next  = free_idx_reg;
        tgt_next       = tgt_reg;
        thr_next       = thr_reg;
        is_hit_next    = is_hit_reg;
        is_evict_next  = is_evict_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        unique case (cmd.phase)
            lrc_pkg::PH_IDLE:
            begin
                if (cmd.take)
                begin
                    kind_next      = s_tuser;
                    font_next      = s_tdata[lrc_pkg::FONT_W-1:0];
                    code_next      = s_tdata[lrc_pkg::FONT_W +: lrc_pkg::CODE_W];
                    found_next     = 1'b0;
                    lru_have_next  = 1'b0;
                    free_have_next = 1'b0;
                    is_hit_next    = 1'b0;
                    is_evict_next  = 1'b0;
                    tgt_next       = '0;
                    rm_cnt_next    = '0;
                    removed_next   = '0;
                end
            end
            lrc_pkg::PH_SCAN:
            begin
                if (cmd.proc)
                begin
                    if (valid_reg[pidx] && (q_font == font_reg) && (q_code == code_reg)
                        && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_idx_next  = pidx;
                        hit_rank_next = q_rank;
                    end
                    if (valid_reg[pidx] && (!lru_have_reg || (q_rank > lru_rank_reg)))
                    begin
                        lru_have_next = 1'b1;
                        lru_idx_next  = pidx;
                        lru_rank_next = q_rank;
                    end
                    if (!valid_reg[pidx] && !free_have_reg)
                    begin
                        free_have_next = 1'b1;
                        free_idx_next  = pidx;
                    end
                end
            end
            lrc_pkg::PH_DECIDE:
            begin
                priority if (found_reg)
                begin
                    tgt_next     = hit_idx_reg;
                    thr_next     = {1'b0, hit_rank_reg};
                    is_hit_next  = 1'b1;
                    hit_tot_next = hit_tot_reg + 1'b1;
                end
                else if ((9'(count_reg) >= eff9) && lru_have_reg)
                begin
                    tgt_next      = lru_idx_reg;
                    thr_next      = {1'b0, lru_rank_reg};
                    is_evict_next = 1'b1;
                    miss_tot_next = miss_tot_reg + 1'b1;
                end
                else
                begin
                    tgt_next      = free_idx_reg;
                    thr_next      = (IW + 1)'(ENTRIES);
                    miss_tot_next = miss_tot_reg + 1'b1;
                end
            end
            lrc_pkg::PH_FILL:
            begin
                valid_next[tgt_reg] = 1'b1;
                if (!is_hit_reg && !is_evict_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            lrc_pkg::PH_MARK:
            begin
                if (cmd.proc && valid_reg[pidx] && ((font_reg == '0) || (q_font == font_reg)))
                begin
                    valid_next[pidx]     = 1'b0;
                    removed_next[q_rank] = 1'b1;
                    count_next           = count_reg - 1'b1;
                end
            end
            lrc_pkg::PH_MAP:
            begin
                rm_cnt_next = rm_cnt_reg + CW'(removed_reg[idx[IW-1:0]]);
            end
            lrc_pkg::PH_DONE:
            begin
                if (cmd.emit)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = {is_evict_reg, is_hit_reg, lookup};
                    out_data_next  = {3'b000, lrc_pkg::LIVE_W'(count_reg), miss_tot_reg,
                                      hit_tot_reg,
                                      lookup ? lrc_pkg::SLOT_W'(tgt_reg) : lrc_pkg::SLOT_W'(0)};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lrc_pkg::CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            font_reg      <= '0;
        end
        else
        begin
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            hit_tot_reg   <= hit_tot_next;
            miss_tot_reg  <= miss_tot_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            font_reg      <= font_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        removed_reg   <= removed_next;
        rm_cnt_reg    <= rm_cnt_next;
        found_reg     <= found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        lru_have_reg  <= lru_have_next;
        lru_idx_reg   <= lru_idx_next;
        lru_rank_reg  <= lru_rank_next;
        free_have_reg <= free_have_next;
        free_idx_reg  <= free_idx_next;
        tgt_reg       <= tgt_next;
        thr_reg       <= thr_next;
        is_hit_reg    <= is_hit_next;
        is_evict_reg  <= is_evict_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    assign stat.is_clear  = (kind_reg == lrc_pkg::KIND_CLEAR);
    assign stat.font_zero = (font_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/core/lru_tag_cache_top.sv =====
// Lookup: load, scan sweep, decide, rank update sweep and fill, then the result.
// Clear: mark sweep, remap table build, then remap per entry in states RM0, RM1, RM2.
// Ignored lookup (font 0) goes straight from load to the result. One item in flight;
// the single tag RAM read port sets the rate: the next item can be accepted in the cycle
// after the result is loaded. The result register lets the next item enter while a
// result waits. Reset clears valid bits, counters and control; capacity is 64.
module lru_tag_cache_top #(
    parameter int ENTRIES = lrc_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrc_pkg::IN_W-1:0]    s_tdata,  // font_id[7:0], codepoint[28:8], zero fill
    input  logic                        s_tuser,  // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // slot[5:0], hit_total[37:6], miss_total[69:38], live_entries[76:70], zero fill
    output logic [lrc_pkg::OUT_W-1:0]   m_tdata,
    output logic [lrc_pkg::FLAG_W-1:0]  m_tuser,  // accepted[0], hit[1], evicted[2]
    input  logic                        cfg_we,
    input  logic [lrc_pkg::CAP_W-1:0]   cfg_wdata
);

    lrc_pkg::cmd_t                cmd;
    lrc_pkg::stat_t               stat;
    logic [$clog2(ENTRIES+1)-1:0] idx;
    logic [$clog2(ENTRIES)-1:0]   pidx;

    lrc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .idx      (idx),
        .pidx     (pidx)
    );

    lrc_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .pidx      (pidx),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .stat      (stat)
    );

`ifndef ASSERT_OFF
    a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tuser[2])
        else $error("hit result not accepted or marked evicted");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[5:0] == 6'd0) && !m_tuser[1] && !m_tuser[2])
        else $error("non-lookup result carries lookup fields");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");
`endif

endmodule
